// ----- hdl/sacl_pkg.sv -----
package sacl_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 32;
    localparam int WAY_OUT_W  = 2;
    localparam int RES_W      = 1 + 1 + WAY_OUT_W + COUNT_W + COUNT_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_BACK     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_ALLOCATE = 2'd2;

    localparam logic [3:0] OFFSET_MIN   = 4'd2;
    localparam logic [3:0] OFFSET_MAX   = 4'd8;
    localparam logic [3:0] OFFSET_RESET = 4'd4;

    // access kinds; the unused code behaves as a data load
    localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/sacl_ram.sv -----
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/set_assoc_cache_tag_lookup_top.sv -----
// Set-associative cache tag lookup with LRU replacement. One access word on the
// s_ side (byte address in tdata, kind in tuser: 0 load, 1 store, 2 fetch, 3 as load)
// gives exactly one result word on the m_ side. After an access is accepted s_tready
// stays low until its result is loaded into the output register, so the lookup takes
// no new access while one is in flight. The set index and tag come from a multiply of
// the block number by the reciprocal of NUM_SETS (the tag in ST_DIV, then the set
// index in ST_REM), then one set row is read from the tag RAM and the ways go one per
// cycle through a single tag compare / age compare unit, then the row is written back
// (not on a store miss without write allocate) and the result is loaded into the
// output register. The output register lets a new access enter while a result waits;
// that access then holds in its output step until m_tready takes the older one. After
// reset a clearing pass writes every set row of the tag RAM; s_tready stays low
// during it, configuration writes are taken as ever.
module set_assoc_cache_tag_lookup_top #(
    parameter int NUM_SETS   = 64,
    parameter int NUM_WAYS   = 4,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wen,
    input  logic [sacl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sacl_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] address
    input  logic [sacl_pkg::KIND_W-1:0]        s_tuser,   // [1:0] access_kind

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] hit, [1] allocated, [3:2] way_used, [35:4] class_accesses,
    // [67:36] class_misses, [71:68] zero
    output logic [sacl_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int EAW    = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int BW     = EAW - 2;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int FLOG2  = $clog2(NUM_SETS + 1) - 1;
    localparam int CLOG2  = $clog2(NUM_SETS);
    localparam int TAG_W  = BW - FLOG2;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W  = WAY_W;
    localparam int ROW_W  = NUM_WAYS * (TAG_W + 2 + AGE_W);

    // ceil(2^RSH / NUM_SETS) gives the exact quotient for every BW-bit block number
    localparam int          PROD_W     = 2 * BW + 1;
    localparam int          RSH        = BW + CLOG2;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << RSH) + 64'(NUM_SETS) - 64'd1)
                                         / 64'(NUM_SETS);
    localparam logic [BW:0] RECIP      = RECIP_FULL[BW:0];

    sacl_pkg::state_t state_reg, state_next;

    // configuration
    logic [3:0] offset_bits_reg;
    logic       write_back_reg;
    logic       write_allocate_reg;

    // access context
    logic [BW-1:0]                 div_reg;
    logic [TAG_W-1:0]              quo_reg;
    logic [SET_W-1:0]              rem_reg;
    logic [sacl_pkg::KIND_W-1:0]   kind_reg;
    logic [SET_W-1:0]              clr_cnt_reg;

    // way scan results
    logic [WAY_W-1:0] way_cnt_reg;
    logic             hit_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic             inv_found_reg;
    logic [WAY_W-1:0] inv_way_reg;
    logic [AGE_W-1:0] oldest_reg;
    logic [WAY_W-1:0] lru_way_reg;

    logic [sacl_pkg::COUNT_W-1:0] inst_acc_reg, inst_mis_reg;
    logic [sacl_pkg::COUNT_W-1:0] data_acc_reg, data_mis_reg;

    logic [sacl_pkg::RES_W-1:0]      res_data_reg;
    logic                            m_valid_reg;
    logic [sacl_pkg::OUT_DATA_W-1:0] m_data_reg;

    // FSM outputs
    logic accept;
    logic ram_we, ram_re, out_load;

    // RAM
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;

    logic [NUM_WAYS-1:0][TAG_W-1:0] row_tag, wr_tag;
    logic [NUM_WAYS-1:0]            row_valid, wr_valid;
    logic [NUM_WAYS-1:0]            row_dirty, wr_dirty;
    logic [NUM_WAYS-1:0][AGE_W-1:0] row_age, wr_age;

    assign {row_age, row_dirty, row_valid, row_tag} = ram_rdata;
    assign ram_wdata = {wr_age, wr_dirty, wr_valid, wr_tag};

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rem_reg),
        .rdata (ram_rdata)
    );

    // address split front end
    logic [3:0]       off_eff;
    logic [EAW-1:0]   addr_eff, addr_shift;
    logic [BW-1:0]    block_in;

    always_comb begin
        off_eff = offset_bits_reg;
        if (offset_bits_reg < sacl_pkg::OFFSET_MIN) begin
            off_eff = sacl_pkg::OFFSET_MIN;
        end else if (offset_bits_reg > sacl_pkg::OFFSET_MAX) begin
            off_eff = sacl_pkg::OFFSET_MAX;
        end
    end

    assign addr_eff   = s_tdata[EAW-1:0];
    assign addr_shift = addr_eff >> off_eff;
    assign block_in   = addr_shift[BW-1:0];

    // block number / NUM_SETS: quotient by reciprocal multiply, then the remainder
    // from the low bits of block - quotient * NUM_SETS
    logic [PROD_W-1:0]      prod;
    logic [TAG_W+SET_W-1:0] qn;
    logic [SET_W-1:0]       rem_next;

    assign prod     = PROD_W'(div_reg) * PROD_W'(RECIP);
    assign qn       = (TAG_W + SET_W)'(quo_reg) * (TAG_W + SET_W)'(NUM_SETS);
    assign rem_next = div_reg[SET_W-1:0] - qn[SET_W-1:0];

    logic [TAG_W-1:0] tag;
    assign tag = quo_reg;

    // shared way compare unit
    logic             cur_valid, cur_match;
    logic [AGE_W-1:0] cur_age;

    assign cur_valid = row_valid[way_cnt_reg];
    assign cur_match = row_tag[way_cnt_reg] == tag;
    assign cur_age   = row_age[way_cnt_reg];

    // update of the set row
    logic             is_store, is_fetch, store_dirty, do_alloc;
    logic [WAY_W-1:0] sel_way;
    logic [AGE_W-1:0] sel_age;

    assign is_store    = kind_reg == sacl_pkg::KIND_STORE;
    assign is_fetch    = kind_reg == sacl_pkg::KIND_FETCH;
    assign store_dirty = write_back_reg && is_store;
    assign do_alloc    = !hit_reg && (!is_store || write_allocate_reg);
    assign sel_way     = hit_reg ? hit_way_reg : (inv_found_reg ? inv_way_reg : lru_way_reg);
    assign sel_age     = row_age[sel_way];

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (state_reg == sacl_pkg::ST_CLEAR) begin
                wr_tag[w]   = '0;
                wr_valid[w] = 1'b0;
                wr_dirty[w] = 1'b0;
                wr_age[w]   = AGE_W'(w);
            end else begin
                wr_tag[w]   = row_tag[w];
                wr_valid[w] = row_valid[w];
                wr_dirty[w] = row_dirty[w];
                if (WAY_W'(w) == sel_way) begin
                    wr_age[w] = '0;
                    if (hit_reg) begin
                        wr_dirty[w] = row_dirty[w] | store_dirty;
                    end else begin
                        wr_tag[w]   = tag;
                        wr_valid[w] = 1'b1;
                        wr_dirty[w] = store_dirty;
                    end
                end else if (row_age[w] < sel_age) begin
                    wr_age[w] = row_age[w] + 1'b1;
                end else begin
                    wr_age[w] = row_age[w];
                end
            end
        end
    end

    assign ram_waddr = (state_reg == sacl_pkg::ST_CLEAR) ? clr_cnt_reg : rem_reg;

    // class counters
    logic [sacl_pkg::COUNT_W-1:0] acc_sel, mis_sel, acc_next, mis_next;
    logic [WAY_W-1:0]             way_res;

    assign acc_sel  = is_fetch ? inst_acc_reg : data_acc_reg;
    assign mis_sel  = is_fetch ? inst_mis_reg : data_mis_reg;
    assign acc_next = (acc_sel == sacl_pkg::COUNT_MAX) ? acc_sel : acc_sel + 32'd1;
    assign mis_next = (hit_reg || mis_sel == sacl_pkg::COUNT_MAX) ? mis_sel : mis_sel + 32'd1;
    assign way_res  = (hit_reg || do_alloc) ? sel_way : '0;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sacl_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sacl_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = sacl_pkg::ST_DIV;
                end
            end
            sacl_pkg::ST_DIV: begin
                state_next = sacl_pkg::ST_REM;
            end
            sacl_pkg::ST_REM: begin
                state_next = sacl_pkg::ST_READ;
            end
            sacl_pkg::ST_READ: begin
                ram_re     = 1'b1;
                state_next = sacl_pkg::ST_SCAN;
            end
            sacl_pkg::ST_SCAN: begin
                if (way_cnt_reg == WAY_W'(NUM_WAYS - 1)) begin
                    state_next = sacl_pkg::ST_UPDATE;
                end
            end
            sacl_pkg::ST_UPDATE: begin
                ram_we     = hit_reg || do_alloc;
                state_next = sacl_pkg::ST_OUT;
            end
            sacl_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg    <= sacl_pkg::OFFSET_RESET;
            write_back_reg     <= 1'b1;
            write_allocate_reg <= 1'b1;
            clr_cnt_reg        <= '0;
            inst_acc_reg       <= '0;
            inst_mis_reg       <= '0;
            data_acc_reg       <= '0;
            data_mis_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    sacl_pkg::CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_wdata;
                    sacl_pkg::CFG_WRITE_BACK:     write_back_reg     <= cfg_wdata[0];
                    sacl_pkg::CFG_WRITE_ALLOCATE: write_allocate_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == sacl_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == sacl_pkg::ST_UPDATE) begin
                if (is_fetch) begin
                    inst_acc_reg <= acc_next;
                    inst_mis_reg <= mis_next;
                end else begin
                    data_acc_reg <= acc_next;
                    data_mis_reg <= mis_next;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, each set up on entry to the step that uses it
    always_ff @(posedge aclk) begin
        case (state_reg)
            sacl_pkg::ST_IDLE: begin
                if (accept) begin
                    div_reg  <= block_in;
                    kind_reg <= s_tuser;
                end
            end
            sacl_pkg::ST_DIV: begin
                quo_reg <= prod[RSH +: TAG_W];
            end
            sacl_pkg::ST_REM: begin
                rem_reg <= rem_next;
            end
            sacl_pkg::ST_READ: begin
                way_cnt_reg   <= '0;
                hit_reg       <= 1'b0;
                hit_way_reg   <= '0;
                inv_found_reg <= 1'b0;
                inv_way_reg   <= '0;
                oldest_reg    <= '0;
                lru_way_reg   <= '0;
            end
            sacl_pkg::ST_SCAN: begin
                if (cur_valid && cur_match && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_way_reg <= way_cnt_reg;
                end
                if (!cur_valid && !inv_found_reg) begin
                    inv_found_reg <= 1'b1;
                    inv_way_reg   <= way_cnt_reg;
                end
                // ties go to the higher way
                if (cur_age >= oldest_reg) begin
                    oldest_reg  <= cur_age;
                    lru_way_reg <= way_cnt_reg;
                end
                way_cnt_reg <= way_cnt_reg + 1'b1;
            end
            sacl_pkg::ST_UPDATE: begin
                res_data_reg <= {mis_next, acc_next, sacl_pkg::WAY_OUT_W'(way_res),
                                 do_alloc, hit_reg};
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg <= sacl_pkg::OUT_DATA_W'(res_data_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("access accepted while previous one in flight");

    a_misses_le_accesses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:36] <= m_tdata[35:4])
        else $error("class miss count exceeds access count");

    a_hit_is_real: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sacl_pkg::ST_UPDATE && hit_reg) |->
            (row_valid[hit_way_reg] && row_tag[hit_way_reg] == tag))
        else $error("hit way does not hold a valid matching tag");

    a_no_write_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == sacl_pkg::ST_CLEAR || state_reg == sacl_pkg::ST_UPDATE))
        else $error("tag RAM written outside clear or update");

endmodule
